// ===== hdl/z80afo_pkg.sv =====
// shared types, flag positions and helpers for the accumulator and flag unit
package z80afo_pkg;

	typedef enum logic [2:0] {
		CMD_DAA  = 3'd0,
		CMD_CPL  = 3'd1,
		CMD_NEG  = 3'd2,
		CMD_CCF  = 3'd3,
		CMD_SCF  = 3'd4,
		CMD_NOFL = 3'd5
	} cmd_t;

	// flag bit positions
	localparam int FLAG_S = 7;
	localparam int FLAG_Z = 6;
	localparam int FLAG_X = 5;
	localparam int FLAG_H = 4;
	localparam int FLAG_Y = 3;
	localparam int FLAG_P = 2;
	localparam int FLAG_N = 1;
	localparam int FLAG_C = 0;

	// decimal adjust limits and correction digit, and the neg overflow value
	localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
	localparam logic [3:0] DAA_LO_LIMIT = 4'hA;
	localparam logic [3:0] DAA_CORR     = 4'h6;
	localparam logic [3:0] DAA_H_BORROW = 4'h6;
	localparam logic [7:0] NEG_OVF_VAL  = 8'h80;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] acc_in;
		logic [7:0] flags_in;
		logic       prev_wrote_flags;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] acc_out;
		logic [7:0] flags_out;
		logic       wrote_flags;
	} out_beat_t;

	// sign, zero, even parity and the two undocumented bits of a result byte
	function automatic logic [7:0] szpxy(input logic [7:0] a);
		logic [7:0] f;
		f         = 8'h00;
		f[FLAG_S] = a[7];
		f[FLAG_Z] = (a == 8'h00);
		f[FLAG_X] = a[5];
		f[FLAG_Y] = a[3];
		f[FLAG_P] = ~^a;
		return f;
	endfunction

endpackage

// ===== hdl/z80afo_if.sv =====
// valid/ready channel interfaces for instruction beats and result beats
interface z80afo_in_if;
	logic                 valid;
	logic                 ready;
	z80afo_pkg::in_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface z80afo_out_if;
	logic                  valid;
	logic                  ready;
	z80afo_pkg::out_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/z80afo_alu.sv =====
// combinational execute logic for daa, cpl, neg, ccf, scf and flagless ops
module z80afo_alu (
	input  z80afo_pkg::in_beat_t  op,
	output z80afo_pkg::out_beat_t res
);
	import z80afo_pkg::*;

	logic [3:0] lo;
	logic       n, h, c;
	logic       lo_fix, hi_fix, daa_h;
	logic [7:0] corr, daa_acc, neg_acc;
	logic [7:0] xy_flags;

	always_comb begin
		lo     = op.acc_in[3:0];
		n      = op.flags_in[FLAG_N];
		h      = op.flags_in[FLAG_H];
		c      = op.flags_in[FLAG_C];
		lo_fix = h || (lo >= DAA_LO_LIMIT);
		hi_fix = c || (op.acc_in > DAA_HI_LIMIT);
		corr   = {(hi_fix ? DAA_CORR : 4'h0), (lo_fix ? DAA_CORR : 4'h0)};
		daa_acc = n ? (op.acc_in - corr) : (op.acc_in + corr);
		daa_h   = n ? (h && (lo < DAA_H_BORROW)) : (lo >= DAA_LO_LIMIT);
		neg_acc = 8'h00 - op.acc_in;

		// ccf/scf: copy a bits 5 and 3 after a flag write, or them in otherwise
		xy_flags = op.flags_in;
		if (op.prev_wrote_flags) begin
			xy_flags[FLAG_X] = op.acc_in[5];
			xy_flags[FLAG_Y] = op.acc_in[3];
		end else begin
			xy_flags[FLAG_X] = op.flags_in[FLAG_X] | op.acc_in[5];
			xy_flags[FLAG_Y] = op.flags_in[FLAG_Y] | op.acc_in[3];
		end

		res.acc_out     = op.acc_in;
		res.flags_out   = op.flags_in;
		res.wrote_flags = 1'b1;

		unique case (op.cmd)
			CMD_DAA: begin
				res.acc_out           = daa_acc;
				res.flags_out         = szpxy(daa_acc);
				res.flags_out[FLAG_H] = daa_h;
				res.flags_out[FLAG_N] = n;
				res.flags_out[FLAG_C] = hi_fix;
			end
			CMD_CPL: begin
				res.acc_out           = ~op.acc_in;
				res.flags_out[FLAG_X] = ~op.acc_in[5];
				res.flags_out[FLAG_Y] = ~op.acc_in[3];
				res.flags_out[FLAG_H] = 1'b1;
				res.flags_out[FLAG_N] = 1'b1;
			end
			CMD_NEG: begin
				res.acc_out           = neg_acc;
				res.flags_out         = szpxy(neg_acc);
				res.flags_out[FLAG_P] = (neg_acc == NEG_OVF_VAL);
				res.flags_out[FLAG_H] = (neg_acc[3:0] != 4'h0);
				res.flags_out[FLAG_N] = 1'b1;
				res.flags_out[FLAG_C] = (neg_acc != 8'h00);
			end
			CMD_CCF: begin
				res.flags_out         = xy_flags;
				res.flags_out[FLAG_H] = c;
				res.flags_out[FLAG_N] = 1'b0;
				res.flags_out[FLAG_C] = ~c;
			end
			CMD_SCF: begin
				res.flags_out         = xy_flags;
				res.flags_out[FLAG_H] = 1'b0;
				res.flags_out[FLAG_N] = 1'b0;
				res.flags_out[FLAG_C] = 1'b1;
			end
			default: begin
				// flagless and unused codes pass through
				res.wrote_flags = 1'b0;
			end
		endcase
	end

endmodule

// ===== hdl/z80_accumulator_flag_ops_unit.sv =====
// top level: two-stage pipeline around the accumulator and flag execute logic
//
//  channel  | role | payload                                      | beat
//  ---------+------+----------------------------------------------+-----------------
//  item     | sink | cmd, acc_in, flags_in, prev_wrote_flags      | one instruction
//  result   | src  | acc_out, flags_out, wrote_flags              | one per item
//
//  one beat per cycle sustained while the result channel does not stall
//  stage 1 registers the instruction, stage 2 registers the executed result
//  the execute logic is a single short pass: 8-bit add/sub for daa and neg and some muxing
//  a stalled result holds stage 2; stage 1 still fills, so two beats can wait
//  reset clears both valid bits; payload registers are not reset
module z80_accumulator_flag_ops_unit (
	input  logic           clk,
	input  logic           arst_n,
	z80afo_in_if.sink      item,
	z80afo_out_if.source   result
);
	import z80afo_pkg::*;

	// stage 1: captured instruction
	logic      valid_s1;
	in_beat_t  op_s1;

	// stage 2: executed result
	logic      valid_s2;
	out_beat_t res_s2;

	out_beat_t res_comb;
	logic      ready_s1, ready_s2;

	// each stage takes a beat when empty or when its contents move on
	assign ready_s2   = !valid_s2 || result.ready;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign item.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && item.valid) begin
			op_s1 <= item.data;
		end
	end

	// single-pass execute
	z80afo_alu u_alu (
		.op  (op_s1),
		.res (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = res_s2;

	// input stalls only when both stages hold beats
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (valid_s1 && valid_s2))
		else $error("input stalled with a free stage");

	// the flags-written mark follows the opcode that produced the result
	a_wrote_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ready_s2) |=> (res_s2.wrote_flags ==
			(($past(op_s1.cmd) == CMD_DAA) || ($past(op_s1.cmd) == CMD_CPL) ||
			 ($past(op_s1.cmd) == CMD_NEG) || ($past(op_s1.cmd) == CMD_CCF) ||
			 ($past(op_s1.cmd) == CMD_SCF))))
		else $error("wrote_flags does not match opcode");

	// a flagless instruction leaves accumulator and flags untouched
	a_flagless_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ready_s2 && !res_comb.wrote_flags) |=>
			((res_s2.acc_out == $past(op_s1.acc_in)) &&
			 (res_s2.flags_out == $past(op_s1.flags_in))))
		else $error("flagless instruction changed state");

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the z80 accumulator and flag unit: table-driven and random beats
`timescale 1ns / 100ps

module tb;
	import z80afo_pkg::*;

	// idle cycles with no beat on either channel before the run is declared hung
	localparam int WATCHDOG_LIMIT = 1000;
	// result side backpressure stretch, long enough to fill both pipeline stages
	localparam int HOLD_CYCLES    = 80;
	// result count at which the long backpressure stretch starts
	localparam int HOLD_AFTER     = 120;
	// random instructions after the table
	localparam int RANDOM_BEATS   = 550;
	// settle time after the last expected result
	localparam int DRAIN_CYCLES   = 10;

	// one row of the directed table; known rows carry a hand-written result
	typedef struct {
		in_beat_t  beat;
		logic      known;
		out_beat_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	z80afo_in_if  item_ch ();
	z80afo_out_if result_ch ();

	z80_accumulator_flag_ops_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always #2 clk = ~clk;

	out_beat_t pending_results[$];   // results still owed by the block, oldest first
	stim_row_t directed_rows[$];
	int        mismatch_count = 0;
	int        results_seen   = 0;
	int        tx_burst       = 0;   // beats left in a no-gap stretch on the item side
	int        rx_burst       = 0;   // cycles left in a no-stall stretch on the result side
	logic      hold_done      = 1'b0;

	// behavior of one instruction: new accumulator, flags and flags-written mark
	function automatic out_beat_t exec_flag_op(input in_beat_t b);
		logic [7:0] a;
		logic [7:0] f;
		logic [7:0] adj;
		logic       lo_fix;
		logic       hi_fix;
		logic       half;
		out_beat_t  r;
		a             = b.acc_in;
		f             = b.flags_in;
		r.wrote_flags = 1'b1;
		case (b.cmd)
			CMD_DAA: begin
				// both decisions and the new H look at the accumulator before adjusting
				lo_fix = f[FLAG_H] || (a[3:0] >= DAA_LO_LIMIT);
				hi_fix = f[FLAG_C] || (a > DAA_HI_LIMIT);
				if (f[FLAG_N])
					half = f[FLAG_H] && (a[3:0] < DAA_H_BORROW);
				else
					half = a[3:0] >= DAA_LO_LIMIT;
				adj = {(hi_fix ? DAA_CORR : 4'h0), (lo_fix ? DAA_CORR : 4'h0)};
				a   = f[FLAG_N] ? a - adj : a + adj;
				f[FLAG_S] = a[7];
				f[FLAG_Z] = (a == 8'h00);
				f[FLAG_X] = a[5];
				f[FLAG_H] = half;
				f[FLAG_Y] = a[3];
				f[FLAG_P] = ~^a;
				f[FLAG_C] = hi_fix;
			end
			CMD_CPL: begin
				a         = ~a;
				f[FLAG_X] = a[5];
				f[FLAG_Y] = a[3];
				f[FLAG_H] = 1'b1;
				f[FLAG_N] = 1'b1;
			end
			CMD_NEG: begin
				a         = 8'h00 - a;
				f         = 8'h00;
				f[FLAG_S] = a[7];
				f[FLAG_Z] = (a == 8'h00);
				f[FLAG_X] = a[5];
				f[FLAG_Y] = a[3];
				f[FLAG_P] = (a == NEG_OVF_VAL);
				f[FLAG_H] = (a[3:0] != 4'h0);
				f[FLAG_N] = 1'b1;
				f[FLAG_C] = (a != 8'h00);
			end
			CMD_CCF: begin
				f[FLAG_H] = f[FLAG_C];
				f[FLAG_C] = ~f[FLAG_C];
				f[FLAG_N] = 1'b0;
			end
			CMD_SCF: begin
				f[FLAG_C] = 1'b1;
				f[FLAG_H] = 1'b0;
				f[FLAG_N] = 1'b0;
			end
			default: r.wrote_flags = 1'b0;
		endcase
		// ccf and scf: X and Y replaced right after a flag writer, otherwise merged in
		if (b.cmd == CMD_CCF || b.cmd == CMD_SCF) begin
			f[FLAG_X] = b.prev_wrote_flags ? a[5] : (f[FLAG_X] | a[5]);
			f[FLAG_Y] = b.prev_wrote_flags ? a[3] : (f[FLAG_Y] | a[3]);
		end
		r.acc_out   = a;
		r.flags_out = f;
		return r;
	endfunction

	// idle length for either side: mostly none or short, a few long, sometimes a clean stretch
	function automatic int pick_idle(inout int burst);
		int r;
		if (burst > 0) begin
			burst--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			burst = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 2);
		if (r < 97)
			return $urandom_range(3, 8);
		return $urandom_range(12, 40);
	endfunction

	task automatic table_row(input cmd_t c, input logic [7:0] a, input logic [7:0] f,
			input logic p, input logic known, input logic [7:0] acc_w,
			input logic [7:0] flags_w, input logic wrote_w);
		stim_row_t row;
		row.beat.cmd              = c;
		row.beat.acc_in           = a;
		row.beat.flags_in         = f;
		row.beat.prev_wrote_flags = p;
		row.known                 = known;
		row.want.acc_out          = acc_w;
		row.want.flags_out        = flags_w;
		row.want.wrote_flags      = wrote_w;
		directed_rows.push_back(row);
	endtask

	// offer one beat from a falling edge, hold it until the block takes it, then
	// queue its result; returns at the falling edge after acceptance
	task automatic send_beat(input in_beat_t b, input out_beat_t want);
		int gap;
		gap = pick_idle(tx_burst);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= b;
		do
			@(posedge clk);
		while (!item_ch.ready);
		pending_results.push_back(want);
		@(negedge clk);
	endtask

	// result side: random stalls, plus one long hold-off so the block backs up
	// into the item channel while the sender keeps offering
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			stall = pick_idle(rx_burst);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			@(negedge clk);
		end
	end

	// result checker: each result beat against the oldest owed result
	always @(posedge clk) begin : check_results
		out_beat_t want;
		if (result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: result beat with nothing owed, got acc %02h flags %02h wrote %0b",
					$time, result_ch.data.acc_out, result_ch.data.flags_out,
					result_ch.data.wrote_flags);
			end else begin
				want = pending_results.pop_front();
				if (result_ch.data.acc_out !== want.acc_out) begin
					mismatch_count++;
					$display("%0t: acc_out expected %02h got %02h",
						$time, want.acc_out, result_ch.data.acc_out);
				end
				if (result_ch.data.flags_out !== want.flags_out) begin
					mismatch_count++;
					$display("%0t: flags_out expected %02h got %02h",
						$time, want.flags_out, result_ch.data.flags_out);
				end
				if (result_ch.data.wrote_flags !== want.wrote_flags) begin
					mismatch_count++;
					$display("%0t: wrote_flags expected %0b got %0b",
						$time, want.wrote_flags, result_ch.data.wrote_flags);
				end
			end
		end
	end

	// watchdog: any beat on either channel restarts the count
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// stimulus: reset, directed table, random instructions, drain
	initial begin
		in_beat_t b;
		arst_n          = 1'b0;
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;

		// flagless passes everything through and clears the mark
		table_row(CMD_NOFL, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF, 8'hFF, 1'b0);
		table_row(CMD_NOFL, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00, 1'b0);
		// neg: zero, the overflow value, and a carry out of the low nibble
		table_row(CMD_NEG,  8'h00, 8'hFF, 1'b1, 1'b1, 8'h00, 8'h42, 1'b1);
		table_row(CMD_NEG,  8'h80, 8'h00, 1'b0, 1'b1, 8'h80, 8'h87, 1'b1);
		table_row(CMD_NEG,  8'h01, 8'h00, 1'b1, 1'b1, 8'hFF, 8'hBB, 1'b1);
		// cpl at both extremes
		table_row(CMD_CPL,  8'h00, 8'h00, 1'b1, 1'b1, 8'hFF, 8'h3A, 1'b1);
		table_row(CMD_CPL,  8'hFF, 8'hFF, 1'b0, 1'b1, 8'h00, 8'hD7, 1'b1);
		// scf and ccf: X/Y copied after a flag writer, merged otherwise
		table_row(CMD_SCF,  8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 8'h01, 1'b1);
		table_row(CMD_SCF,  8'hFF, 8'h00, 1'b0, 1'b1, 8'hFF, 8'h29, 1'b1);
		table_row(CMD_CCF,  8'h00, 8'h01, 1'b1, 1'b1, 8'h00, 8'h10, 1'b1);
		table_row(CMD_CCF,  8'h28, 8'hD6, 1'b0, 1'b0, '0, '0, 1'b0);
		table_row(CMD_CCF,  8'h00, 8'h28, 1'b1, 1'b0, '0, '0, 1'b0);
		table_row(CMD_CCF,  8'h00, 8'h28, 1'b0, 1'b0, '0, '0, 1'b0);
		// daa: no adjust, each adjust trigger, subtract mode half-carry split
		table_row(CMD_DAA,  8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 8'h44, 1'b1);
		table_row(CMD_DAA,  8'h0A, 8'h00, 1'b1, 1'b0, '0, '0, 1'b0);
		table_row(CMD_DAA,  8'h9A, 8'h00, 1'b1, 1'b0, '0, '0, 1'b0);
		table_row(CMD_DAA,  8'h99, 8'h00, 1'b1, 1'b0, '0, '0, 1'b0);
		table_row(CMD_DAA,  8'h15, 8'h01, 1'b0, 1'b0, '0, '0, 1'b0);
		table_row(CMD_DAA,  8'h05, 8'h10, 1'b1, 1'b0, '0, '0, 1'b0);
		table_row(CMD_DAA,  8'h03, 8'h12, 1'b1, 1'b0, '0, '0, 1'b0);
		table_row(CMD_DAA,  8'h08, 8'h12, 1'b1, 1'b0, '0, '0, 1'b0);
		table_row(CMD_DAA,  8'hFF, 8'h13, 1'b1, 1'b0, '0, '0, 1'b0);
		table_row(CMD_DAA,  8'hFA, 8'h02, 1'b1, 1'b0, '0, '0, 1'b0);
		table_row(CMD_DAA,  8'h99, 8'hFF, 1'b0, 1'b0, '0, '0, 1'b0);

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_beat(directed_rows[i].beat,
				directed_rows[i].known ? directed_rows[i].want
					: exec_flag_op(directed_rows[i].beat));

		// random instructions; every flag combination and accumulator value reachable
		repeat (RANDOM_BEATS) begin
			b.cmd              = cmd_t'($urandom_range(0, 5));
			b.acc_in           = 8'($urandom);
			b.flags_in         = 8'($urandom);
			b.prev_wrote_flags = 1'($urandom);
			send_beat(b, exec_flag_op(b));
		end
		item_ch.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
